// File: rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants for the LRU page table: the item and result
// layouts, the internal command passed from front to back, and operation codes.
// ----------------------------------------------------------------------------
package lpt_pkg;

	localparam int PAGE_W     = 20;
	localparam int ADDR_W     = 32;
	localparam int CNT_OUT_W  = 5;
	localparam int CAP_W      = 5;
	localparam int PAGE_SHIFT = 12;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [1:0] FUNC_ACCESS  = 2'd0;
	localparam logic [1:0] FUNC_FLUSH   = 2'd1;
	localparam logic [1:0] FUNC_DISCARD = 2'd2;

	typedef enum logic [1:0] {
		OP_ACCESS  = 2'd0,
		OP_FLUSH   = 2'd1,
		OP_DISCARD = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
		logic [PAGE_W-1:0] page_number;
		logic              is_write;
	} in_t;

	typedef struct packed {
		logic                 hit;
		logic                 load_valid;
		logic [PAGE_W-1:0]    load_page;
		logic                 writeback_valid;
		logic [PAGE_W-1:0]    writeback_page;
		logic [CNT_OUT_W-1:0] resident_count;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [PAGE_W-1:0] page;
		logic              wr;
	} cmd_t;

endpackage

// File: rtl/lpt_front.sv
// ----------------------------------------------------------------------------
// lpt_front
// Accepts input beats, decodes the operation and extracts the page number
// into an internal command for the command queue.
// ----------------------------------------------------------------------------
module lpt_front (
	input  logic         push,
	input  lpt_pkg::in_t push_data,
	input  logic         q_full,
	output logic         q_wr,
	output lpt_pkg::cmd_t q_wr_data
);
	import lpt_pkg::*;

	logic [ADDR_W-1:0] shifted;

	assign shifted = push_data.address >> PAGE_SHIFT;
	assign q_wr    = push & ~q_full;

	always_comb begin
		q_wr_data.page = push_data.page_number;
		q_wr_data.wr   = 1'b0;
		unique case (push_data.func)
			FUNC_ACCESS: begin
				q_wr_data.op   = OP_ACCESS;
				q_wr_data.page = shifted[PAGE_W-1:0];
				q_wr_data.wr   = push_data.is_write;
			end
			FUNC_FLUSH:   q_wr_data.op = OP_FLUSH;
			FUNC_DISCARD: q_wr_data.op = OP_DISCARD;
			default:      q_wr_data.op = OP_NOP;
		endcase
	end

endmodule

// File: rtl/lpt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lpt_cmd_fifo
// Two-entry command queue decoupling the front decode from the table update.
// ----------------------------------------------------------------------------
module lpt_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lpt_pkg::cmd_t wr_data,
	input  logic          rd,
	output lpt_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);
	import lpt_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	cnt_le_two: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue count out of range");
	ptrs_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue pointers inconsistent with count");
	rd_moves: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd |=> (rd_ptr_q != $past(rd_ptr_q)))
		else $error("command queue read pointer did not advance");

endmodule

// File: rtl/lpt_back.sv
// ----------------------------------------------------------------------------
// lpt_back
// Page table slots with LRU ranks. A lookup cycle compares every slot against
// the command page and finds the LRU and free slots; an update cycle applies
// the operation and loads the result register.
// ----------------------------------------------------------------------------
module lpt_back #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lpt_pkg::CAP_W-1:0]   cfg_wr_data,
	input  lpt_pkg::cmd_t               q_rd_data,
	input  logic                        q_empty,
	output logic                        q_rd,
	input  logic                        pop,
	output logic                        empty,
	output lpt_pkg::out_t               pop_data
);
	import lpt_pkg::*;

	localparam int N    = MAX_ENTRIES;
	localparam int RW   = $clog2(N);
	localparam int CW   = $clog2(N + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int OW   = (CMPW > CNT_OUT_W) ? CMPW : CNT_OUT_W;

	logic [N-1:0]      valid_q;
	logic [N-1:0]      dirty_q;
	logic [RW-1:0]     rank_q [N];
	logic [PAGE_W-1:0] page_q [N];
	logic [CW-1:0]     count_q;
	logic [CAP_W-1:0]  cap_q;

	cmd_t              cmd_s2;
	logic [N-1:0]      match_s2;
	logic [N-1:0]      lru_s2;
	logic [N-1:0]      free_s2;
	logic              hit_s2;
	logic              evict_s2;
	logic [RW-1:0]     rh_s2;
	logic              s2_valid_q;

	out_t              res_q;
	logic              res_valid_q;

	logic [CMPW-1:0]   cap_eff;
	logic [CW-1:0]     last_cnt;
	logic [RW-1:0]     last_rank;
	logic [N-1:0]      match_c;
	logic [N-1:0]      lru_c;
	logic [N-1:0]      fv_c;
	logic [N-1:0]      free_c;
	logic              hit_c;
	logic              evict_c;
	logic [RW-1:0]     rh_c;
	logic              lookup_fire;
	logic              update_fire;
	logic              out_free;

	logic [N-1:0]      sel;
	logic              wb_valid;
	logic [PAGE_W-1:0] wb_page;
	logic              is_access;
	logic              load_valid;
	logic [CW-1:0]     count_nx;
	logic [OW-1:0]     count_ext;

	assign out_free    = ~res_valid_q | pop;
	assign lookup_fire = ~s2_valid_q & ~q_empty;
	assign update_fire = s2_valid_q & out_free;
	assign q_rd        = lookup_fire;
	assign empty       = ~res_valid_q;
	assign pop_data    = res_q;

	// effective capacity, clamped to 1..N
	always_comb begin
		if (cap_q == '0)
			cap_eff = CMPW'(1);
		else if (CMPW'(cap_q) > CMPW'(N))
			cap_eff = CMPW'(N);
		else
			cap_eff = CMPW'(cap_q);
	end

	assign last_cnt  = count_q - CW'(1);
	assign last_rank = last_cnt[RW-1:0];

	always_comb begin
		rh_c = '0;
		for (int i = 0; i < N; i++) begin
			match_c[i] = valid_q[i] && (page_q[i] == q_rd_data.page) &&
				(q_rd_data.op != OP_NOP);
			lru_c[i]   = valid_q[i] && (rank_q[i] == last_rank);
			rh_c       = rh_c | (match_c[i] ? rank_q[i] : '0);
		end
		hit_c   = |match_c;
		evict_c = (q_rd_data.op == OP_ACCESS) && !hit_c && (CMPW'(count_q) >= cap_eff);
		fv_c    = ~valid_q | (evict_c ? lru_c : '0);
		free_c  = fv_c & (~fv_c + N'(1));
	end

	always_ff @(posedge clk) begin
		if (lookup_fire) begin
			cmd_s2   <= q_rd_data;
			match_s2 <= match_c;
			lru_s2   <= evict_c ? lru_c : '0;
			free_s2  <= free_c;
			hit_s2   <= hit_c;
			evict_s2 <= evict_c;
			rh_s2    <= rh_c;
		end
	end

	assign is_access  = cmd_s2.op == OP_ACCESS;
	assign load_valid = is_access & ~hit_s2;
	assign sel        = is_access ? lru_s2 : match_s2;

	always_comb begin
		wb_page = '0;
		for (int i = 0; i < N; i++)
			wb_page = wb_page | ((sel[i] & dirty_q[i]) ? page_q[i] : '0);
		wb_valid = |(sel & dirty_q);
	end

	always_comb begin
		count_nx = count_q;
		if (load_valid && !evict_s2)
			count_nx = count_q + CW'(1);
		else if (cmd_s2.op == OP_DISCARD && hit_s2)
			count_nx = count_q - CW'(1);
	end

	assign count_ext = OW'(count_nx);

	// slot state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			for (int i = 0; i < N; i++)
				rank_q[i] <= '0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			s2_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
			if (lookup_fire)
				s2_valid_q <= 1'b1;
			else if (update_fire)
				s2_valid_q <= 1'b0;
			if (update_fire)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			if (update_fire) begin
				count_q <= count_nx;
				for (int i = 0; i < N; i++) begin
					case (cmd_s2.op)
						OP_ACCESS: begin
							if (hit_s2) begin
								if (match_s2[i]) begin
									rank_q[i]  <= '0;
									dirty_q[i] <= dirty_q[i] | cmd_s2.wr;
								end else if (valid_q[i] && rank_q[i] < rh_s2) begin
									rank_q[i] <= rank_q[i] + RW'(1);
								end
							end else if (free_s2[i]) begin
								valid_q[i] <= 1'b1;
								dirty_q[i] <= cmd_s2.wr;
								rank_q[i]  <= '0;
							end else if (lru_s2[i]) begin
								valid_q[i] <= 1'b0;
								dirty_q[i] <= 1'b0;
								rank_q[i]  <= '0;
							end else if (valid_q[i]) begin
								rank_q[i] <= rank_q[i] + RW'(1);
							end
						end
						OP_FLUSH: begin
							if (match_s2[i])
								dirty_q[i] <= 1'b0;
						end
						OP_DISCARD: begin
							if (match_s2[i]) begin
								valid_q[i] <= 1'b0;
								dirty_q[i] <= 1'b0;
								rank_q[i]  <= '0;
							end else if (hit_s2 && valid_q[i] && rank_q[i] > rh_s2) begin
								rank_q[i] <= rank_q[i] - RW'(1);
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update_fire) begin
			for (int i = 0; i < N; i++)
				if (load_valid && free_s2[i])
					page_q[i] <= cmd_s2.page;
			res_q.hit             <= hit_s2;
			res_q.load_valid      <= load_valid;
			res_q.load_page       <= load_valid ? cmd_s2.page : '0;
			res_q.writeback_valid <= wb_valid;
			res_q.writeback_page  <= wb_page;
			res_q.resident_count  <= count_ext[CNT_OUT_W-1:0];
		end
	end

	count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("resident count disagrees with valid slots");
	count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= N)
		else $error("resident count above slot count");
	single_match: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> $onehot0(match_s2))
		else $error("page resident in more than one slot");
	single_lru: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && evict_s2) |-> ($onehot(lru_s2) && $onehot(free_s2)))
		else $error("eviction without a unique lru and free slot");
	result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		update_fire |=> res_valid_q)
		else $error("update did not load the result register");

endmodule

// File: rtl/lru_page_table.sv
// ----------------------------------------------------------------------------
// lru_page_table
// Fully associative page table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each operation passes through the table in a lookup step and an update
// step: the lookup compares all MAX_ENTRIES slots in parallel and locates
// the LRU and first free slot, and the update rewrites the ranks, flags and
// result. The single slot array is read then written per operation, so a
// new operation waits in the queue until the previous one is updated, and an
// update waits while an unpopped result holds the result register. An input
// beat goes into the command queue, is registered by the lookup, then is
// loaded by the update. Inputs are still taken while a result waits.
module lru_page_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  lpt_pkg::in_t              push_data,
	output logic                      full,
	input  logic                      pop,
	output logic                      empty,
	output lpt_pkg::out_t             pop_data,
	input  logic                      cfg_wr_en,
	input  logic [lpt_pkg::CAP_W-1:0] cfg_wr_data
);
	import lpt_pkg::*;

	logic q_wr;
	logic q_rd;
	logic q_empty;
	cmd_t q_wr_data;
	cmd_t q_rd_data;

	lpt_front u_front (
		.push      (push),
		.push_data (push_data),
		.q_full    (full),
		.q_wr      (q_wr),
		.q_wr_data (q_wr_data)
	);

	lpt_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.full    (full),
		.empty   (q_empty)
	);

	lpt_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_rd_data   (q_rd_data),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.pop_data    (pop_data)
	);

endmodule
